[rtl/satlb_pkg.sv]
// Shared types and constants for the set-associative TLB.
`default_nettype none
package satlb_pkg;
  localparam int unsigned Sets = 16;
  localparam int unsigned Ways = 4;
  localparam int unsigned PageW = 52;
  localparam int unsigned StampW = 64;
  localparam int unsigned SetW = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int unsigned WayW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned Entries = Sets * Ways;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OpLookup = 2'd0,
    OpInsert = 2'd1,
    OpFlush  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PageW-1:0]  vpage;
    logic [PageW-1:0]  ppage;
    logic              touch;
    logic [StampW-1:0] stamp;
  } cmd_t;

  function automatic logic [SetW-1:0] set_of(input logic [PageW-1:0] vp);
    set_of = (Sets > 1) ? vp[SetW-1:0] : '0;
  endfunction
endpackage
`default_nettype wire

[rtl/satlb_front.sv]
// Front end: accepts words, stamps them and queues them for the back end.
`default_nettype none
module satlb_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [satlb_pkg::PageW-1:0]  virtual_page_i,
  input  wire logic [satlb_pkg::PageW-1:0]  physical_page_i,
  input  wire logic                         touch_recency_i,
  input  wire logic                         pop_i,
  output logic                              cmd_valid_o,
  output satlb_pkg::cmd_t                   cmd_o
);
  logic [satlb_pkg::StampW-1:0] stamp_q, stamp_d;
  satlb_pkg::cmd_t fifo_q [satlb_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic push;

  assign busy = (cnt_q == 2'(satlb_pkg::QDepth));
  assign push = start && !busy;
  assign stamp_d = stamp_q + 64'd1;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= 64'd1;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        stamp_q <= stamp_d;
        wp_q <= ~wp_q;
      end
      if (pop_i) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{op: satlb_pkg::op_e'(opcode_i), vpage: virtual_page_i,
                        ppage: physical_page_i, touch: touch_recency_i,
                        stamp: stamp_q};
    end
  end
endmodule
`default_nettype wire

[rtl/satlb_back.sv]
// Back end: reads a set, compares ways, picks a victim, writes back.
`default_nettype none
module satlb_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire satlb_pkg::cmd_t              cmd_i,
  output logic                              pop_o,
  output logic                              done,
  output logic                              hit_o,
  output logic [satlb_pkg::PageW-1:0]       found_page_o
);
  localparam int unsigned W = satlb_pkg::Ways;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;
  satlb_pkg::cmd_t cur_q;

  // valid bits live in flops; flush clears them at once, pages and stamps stay
  logic [satlb_pkg::Entries-1:0] valid_q;
  logic [satlb_pkg::PageW-1:0]  vp_mem [satlb_pkg::Sets][W];
  logic [satlb_pkg::PageW-1:0]  pp_mem [satlb_pkg::Sets][W];
  logic [satlb_pkg::StampW-1:0] st_mem [satlb_pkg::Sets][W];
  logic [satlb_pkg::PageW-1:0]  vp_rd [W];
  logic [satlb_pkg::PageW-1:0]  pp_rd [W];
  logic [satlb_pkg::StampW-1:0] st_rd [W];

  logic [satlb_pkg::SetW-1:0] set_in, set_cur;
  logic [W-1:0] vld, match;
  logic any_hit, any_free, do_hit_touch, do_fill;
  logic [satlb_pkg::WayW-1:0] hit_way, free_way, old_way, vict_way;
  logic [satlb_pkg::PageW-1:0] hit_pp;
  logic is_lu;

  assign set_in = satlb_pkg::set_of(cmd_i.vpage);
  assign set_cur = satlb_pkg::set_of(cur_q.vpage);
  assign pop_o = cmd_valid_i && (state_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
      for (int w = 0; w < W; w++) begin
        vp_rd[w] <= vp_mem[set_in][w];
        pp_rd[w] <= pp_mem[set_in][w];
        st_rd[w] <= st_mem[set_in][w];
      end
    end
  end

  always_comb begin
    is_lu = (cur_q.op == satlb_pkg::OpLookup) || (cur_q.op == satlb_pkg::OpInsert);
    any_hit = 1'b0;
    any_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    old_way = '0;
    hit_pp = '0;
    for (int w = 0; w < W; w++) begin
      vld[w] = valid_q[{set_cur, satlb_pkg::WayW'(w)} >> 0];
      match[w] = vld[w] && (vp_rd[w] == cur_q.vpage);
    end
    for (int w = W - 1; w >= 0; w--) begin
      if (match[w]) begin
        any_hit = 1'b1;
        hit_way = satlb_pkg::WayW'(w);
        hit_pp = pp_rd[w];
      end
      if (!vld[w]) begin
        any_free = 1'b1;
        free_way = satlb_pkg::WayW'(w);
      end
    end
    for (int w = 1; w < W; w++) begin
      if (st_rd[w] < st_rd[old_way]) old_way = satlb_pkg::WayW'(w);
    end
    vict_way = any_free ? free_way : old_way;
    do_hit_touch = is_lu && any_hit &&
                   ((cur_q.op == satlb_pkg::OpInsert) || cur_q.touch);
    do_fill = (cur_q.op == satlb_pkg::OpInsert) && !any_hit;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (pop_o) state_d = StExec;
      StExec: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      done <= 1'b0;
    end else begin
      state_q <= state_d;
      done <= (state_q == StExec);
      if (state_q == StExec) begin
        if (cur_q.op == satlb_pkg::OpFlush) valid_q <= '0;
        else if (do_fill) valid_q[{set_cur, vict_way}] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StExec) begin
      hit_o <= is_lu && any_hit;
      found_page_o <= (is_lu && any_hit) ? hit_pp : '0;
      if (do_hit_touch) st_mem[set_cur][hit_way] <= cur_q.stamp;
      if (do_fill) begin
        vp_mem[set_cur][vict_way] <= cur_q.vpage;
        pp_mem[set_cur][vict_way] <= cur_q.ppage;
        st_mem[set_cur][vict_way] <= cur_q.stamp;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/set_assoc_tlb_lru.sv]
// A word is queued, read into the back end's registers, executed, then done
// is registered. The back end reads the next word only after executing one.
// A two-entry queue decouples the front end; busy rises when it is full.
// Results cannot be stalled. Reset is immediate: all entries free, stamp = 1.
// Stamps of freed ways are kept in memory as after a flush.
`default_nettype none
module set_assoc_tlb_lru (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [satlb_pkg::PageW-1:0]  virtual_page_i,
  input  wire logic [satlb_pkg::PageW-1:0]  physical_page_i,
  input  wire logic                         touch_recency_i,
  output logic                              done,
  output logic                              hit_o,
  output logic [satlb_pkg::PageW-1:0]       found_page_o
);
  logic pop, cmd_valid;
  satlb_pkg::cmd_t cmd;

  satlb_front u_front (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .virtual_page_i,
    .physical_page_i, .touch_recency_i, .pop_i(pop),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd)
  );

  satlb_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .pop_o(pop),
    .done, .hit_o, .found_page_o
  );
endmodule
`default_nettype wire

[rtl/satlb_checker.sv]
// Port-level checker for the TLB, bound to the top level.
`default_nettype none
module satlb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic                        hit_o,
  input wire logic [satlb_pkg::PageW-1:0] found_page_o
);
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("back-to-back done");
  a_no_done_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done) else $error("done right after reset");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !hit_o) |-> (found_page_o == '0)) else $error("miss with page");
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without a word");
endmodule

bind set_assoc_tlb_lru satlb_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done, .hit_o, .found_page_o
);
`default_nettype wire
